@@ hw/rtl/ptcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcs_pkg
// Shared types and constants for the periodic tick compare scheduler.
// ----------------------------------------------------------------------------
package ptcs_pkg;

   localparam int TICK_W     = 64;
   localparam int MS_W       = 32;
   localparam int PERIOD_W   = 20;
   localparam int SLACK_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;
   localparam int DIV_CNT_W  = $clog2(TICK_W);

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(6000);
   localparam logic [SLACK_W-1:0]  SLACK_RESET  = SLACK_W'(32);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLACK  = 1'b1;

   localparam logic ACTION_RESTART = 1'b0;
   localparam logic ACTION_COMPARE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
      logic check;
      logic div_step;
      logic catch_up;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic compare;
      logic behind;
      logic div_last;
   } status_type;

endpackage

@@ hw/rtl/ptcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptcs_ctrl
// Sequencer: walks one word through advance, check, divide, catch-up and
// finish steps and owns both handshakes.
// ----------------------------------------------------------------------------
module ptcs_ctrl import ptcs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_ADVANCE = 6'b000010,
      ST_CHECK   = 6'b000100,
      ST_DIV     = 6'b001000,
      ST_CATCH   = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = sts.compare ? ST_CHECK : ST_FINISH;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.behind ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CATCH;
            end
         end
         ST_CATCH: begin
            cmd.catch_up = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the word
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/ptcs_datapath.sv @@
// ----------------------------------------------------------------------------
// ptcs_datapath
// Millisecond count, compare target, config registers, the bit-serial
// catch-up divider and the output register.
// ----------------------------------------------------------------------------
module ptcs_datapath import ptcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_action,
   input  logic [TICK_W-1:0]     req_now_ticks,
   input  cmd_type               cmd,
   output status_type            sts,
   output logic [MS_W-1:0]       rsp_millis,
   output logic [TICK_W-1:0]     rsp_next_target,
   output logic [MS_W-1:0]       rsp_missed_periods,
   output logic                  rsp_rebased
);

   logic [PERIOD_W-1:0]  period_ff;
   logic [SLACK_W-1:0]   slack_ff;
   logic [MS_W-1:0]      ms_ff;
   logic [TICK_W-1:0]    target_ff;
   logic [TICK_W-1:0]    now_ff;
   logic                 action_ff;
   logic [TICK_W-1:0]    div_ff;
   logic [PERIOD_W-1:0]  rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 close_ff;
   logic [MS_W-1:0]      missed_ff;
   logic [MS_W-1:0]      out_ms_ff;
   logic [TICK_W-1:0]    out_target_ff;
   logic [MS_W-1:0]      out_missed_ff;
   logic                 out_rebased_ff;

   logic [PERIOD_W-1:0]  per;
   logic [TICK_W-1:0]    diff;
   logic [PERIOD_W:0]    rem_sh;
   logic                 q_bit;
   logic [PERIOD_W-1:0]  rem_in;
   logic [PERIOD_W-1:0]  gap;
   logic [MS_W-1:0]      k_lo;
   logic                 k_sat;
   logic [TICK_W-1:0]    rebase_target;

   // a zero period counts as one
   assign per  = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign diff = target_ff - now_ff;

   // restoring divider step: behind / period, one quotient bit a cycle
   assign rem_sh = {rem_ff, div_ff[TICK_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, per});
   assign rem_in = q_bit ? PERIOD_W'(rem_sh - {1'b0, per}) : rem_sh[PERIOD_W-1:0];

   // after catch-up the distance to now is period minus remainder
   assign gap   = per - rem_ff;
   assign k_lo  = div_ff[MS_W-1:0] + MS_W'(1);
   assign k_sat = (div_ff[TICK_W-1:MS_W] != '0) || (&div_ff[MS_W-1:0]);

   assign rebase_target = now_ff + TICK_W'(per);

   assign sts.compare  = (action_ff == ACTION_COMPARE);
   assign sts.behind   = (diff == '0) || diff[TICK_W-1];
   assign sts.div_last = (cnt_ff == DIV_CNT_W'(TICK_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         slack_ff  <= SLACK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_SLACK:  slack_ff  <= csr_wdata[SLACK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff     <= '0;
         target_ff <= TICK_W'(PERIOD_RESET);
      end else if (cmd.advance) begin
         if (action_ff == ACTION_COMPARE) begin
            ms_ff     <= ms_ff + MS_W'(1);
            target_ff <= target_ff + TICK_W'(per);
         end else begin
            ms_ff     <= '0;
            target_ff <= TICK_W'(per);
         end
      end else if (cmd.catch_up) begin
         ms_ff     <= ms_ff + k_lo;
         target_ff <= now_ff + TICK_W'(gap);
      end else if (cmd.finish && close_ff) begin
         target_ff <= rebase_target;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         now_ff    <= req_now_ticks;
         missed_ff <= '0;
         close_ff  <= 1'b0;
      end
      if (cmd.check) begin
         div_ff   <= now_ff - target_ff;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         close_ff <= (diff[TICK_W-1:SLACK_W] == '0) && (diff[SLACK_W-1:0] < slack_ff);
      end
      if (cmd.div_step) begin
         div_ff <= {div_ff[TICK_W-2:0], q_bit};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.catch_up) begin
         missed_ff <= k_sat ? '1 : k_lo;
         close_ff  <= (gap < PERIOD_W'(slack_ff));
      end
      if (cmd.finish) begin
         out_ms_ff      <= ms_ff;
         out_target_ff  <= close_ff ? rebase_target : target_ff;
         out_missed_ff  <= missed_ff;
         out_rebased_ff <= close_ff;
      end
   end

   assign rsp_millis         = out_ms_ff;
   assign rsp_next_target    = out_target_ff;
   assign rsp_missed_periods = out_missed_ff;
   assign rsp_rebased        = out_rebased_ff;

endmodule

@@ hw/rtl/periodic_tick_compare_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_tick_compare_scheduler
// Millisecond tick scheduler on a free-running 64-bit counter with
// missed-tick catch-up and a minimum-slack rebase.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: action (restart or compare match) and the counter value now.
//   rsp_ channel: millisecond count, next compare target, missed periods and
//   the rebase flag; exactly one word per request word.
//   csr_ port: index 0 period in ticks, index 1 minimum slack; write while idle.
// Steps: a restart goes through advance and finish, an on-time compare
//   through advance, check and finish, and a late compare through divide
//   and catch-up too; the catch-up count comes from a restoring divider that
//   retires one quotient bit per cycle over all 64 bits of the lag.
// Throughput: one word at a time; req_ready is high only while the sequencer
//   is idle, so the next word enters in the cycle after the result is loaded.
// Reset: count cleared, target set to 6000, period 6000, slack 32.
// Stall: the result sits in an output register; a new word is accepted
//   meanwhile, and its result waits until the old one is taken.
// ----------------------------------------------------------------------------
module periodic_tick_compare_scheduler import ptcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [TICK_W-1:0]     req_now_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MS_W-1:0]       rsp_millis,
   output logic [TICK_W-1:0]     rsp_next_target,
   output logic [MS_W-1:0]       rsp_missed_periods,
   output logic                  rsp_rebased
);

   cmd_type    cmd;
   status_type sts;

   ptcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptcs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_now_ticks      (req_now_ticks),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_millis         (rsp_millis),
      .rsp_next_target    (rsp_next_target),
      .rsp_missed_periods (rsp_missed_periods),
      .rsp_rebased        (rsp_rebased)
   );

endmodule

@@ test/periodic_tick_compare_scheduler_tb.sv @@
// ----------------------------------------------------------------------------
// periodic_tick_compare_scheduler_tb
// Drives restart and compare-match words into the tick scheduler and checks
// each result word against a local schedule model. A short directed table
// covers reset values, counter extremes, zero period, half-range lag and
// masked register writes. Random phases then follow, each with its own
// period and slack settings, mostly bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module periodic_tick_compare_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptcs_pkg::*;

   localparam int LIMIT       = 1_000_000;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 125;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 10;
   localparam int TAIL_CYCLES = 80;

   typedef struct packed {
      logic [MS_W-1:0]   millis;
      logic [TICK_W-1:0] next_target;
      logic [MS_W-1:0]   missed_periods;
      logic              rebased;
   } tick_word_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  action;
      logic [TICK_W-1:0]     now;
      logic                  typed;
      tick_word_type         want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_action;
   logic [TICK_W-1:0]     req_now_ticks;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [MS_W-1:0]       rsp_millis;
   logic [TICK_W-1:0]     rsp_next_target;
   logic [MS_W-1:0]       rsp_missed_periods;
   logic                  rsp_rebased;

   // local copy of the schedule state and registers
   logic [MS_W-1:0]     ms_model;
   logic [TICK_W-1:0]   target_model;
   logic [PERIOD_W-1:0] period_model;
   logic [SLACK_W-1:0]  slack_model;

   tick_word_type pending_ticks [$];
   tick_word_type seen_word;
   tick_word_type due_word;
   int            mismatches  = 0;
   int            holds_asked = 0;

   periodic_tick_compare_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_now_ticks      (req_now_ticks),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_millis         (rsp_millis),
      .rsp_next_target    (rsp_next_target),
      .rsp_missed_periods (rsp_missed_periods),
      .rsp_rebased        (rsp_rebased)
   );

   always #6 clock = ~clock;

   function automatic tick_word_type schedule_tick(input logic action,
                                                   input logic [TICK_W-1:0] now);
      tick_word_type     res;
      logic [TICK_W-1:0] step;
      logic [TICK_W-1:0] gap;
      logic [TICK_W-1:0] lag;
      logic [TICK_W-1:0] periods;
      step = (period_model == '0) ? 64'd1 : {44'd0, period_model};
      res  = '0;
      if (action == ACTION_RESTART) begin
         ms_model     = '0;
         target_model = step;
      end else begin
         ms_model     = ms_model + 32'd1;
         target_model = target_model + step;
         gap          = target_model - now;
         // zero or negative distance: skip whole periods until ahead of now
         if (gap == '0 || gap[TICK_W-1]) begin
            lag          = now - target_model;
            periods      = lag / step + 64'd1;
            ms_model     = ms_model + periods[MS_W-1:0];
            target_model = target_model + periods * step;
            res.missed_periods = (periods > 64'hFFFF_FFFF) ? '1 : periods[MS_W-1:0];
            gap          = target_model - now;
         end
         if (gap < {48'd0, slack_model}) begin
            target_model = now + step;
            res.rebased  = 1'b1;
         end
      end
      res.millis      = ms_model;
      res.next_target = target_model;
      return res;
   endfunction

   function automatic plan_row_type word_row(input logic action,
                                             input logic [TICK_W-1:0] now);
      plan_row_type r;
      r        = '0;
      r.kind   = ROW_WORD;
      r.action = action;
      r.now    = now;
      return r;
   endfunction

   // rows whose result is obvious: nothing missed, no rebase
   function automatic plan_row_type typed_row(input logic action,
                                              input logic [TICK_W-1:0] now,
                                              input logic [MS_W-1:0] ms,
                                              input logic [TICK_W-1:0] tgt);
      plan_row_type r;
      r                  = word_row(action, now);
      r.typed            = 1'b1;
      r.want.millis      = ms;
      r.want.next_target = tgt;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r      = '0;
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.data = data;
      return r;
   endfunction

   task automatic send_word(input logic action, input logic [TICK_W-1:0] now,
                            input logic typed, input tick_word_type want);
      tick_word_type got;
      req_valid     <= 1'b1;
      req_action    <= action;
      req_now_ticks <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = schedule_tick(action, now);
      pending_ticks.push_back(typed ? want : got);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_PERIOD) period_model = data[PERIOD_W-1:0];
      else slack_model = data[SLACK_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      while (pending_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input tick_word_type want,
                                input tick_word_type got);
      if (mismatches < MAX_REPORTS)
         $display("%0t %s: expected ms %0d target %h missed %0d rebased %0b",
                  $realtime, what, want.millis, want.next_target,
                  want.missed_periods, want.rebased,
                  " / got ms %0d target %h missed %0d rebased %0b",
                  got.millis, got.next_target, got.missed_periods, got.rebased);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_word.millis         = rsp_millis;
         seen_word.next_target    = rsp_next_target;
         seen_word.missed_periods = rsp_missed_periods;
         seen_word.rebased        = rsp_rebased;
         if (pending_ticks.size() == 0) begin
            flag_mismatch("result word with nothing pending", '0, seen_word);
         end else begin
            due_word = pending_ticks.pop_front();
            if (seen_word.millis !== due_word.millis ||
                seen_word.next_target !== due_word.next_target ||
                seen_word.missed_periods !== due_word.missed_periods ||
                seen_word.rebased !== due_word.rebased)
               flag_mismatch("result word differs", due_word, seen_word);
         end
      end
   end

   initial begin : receiver
      int unsigned mode;
      int unsigned left;
      int unsigned beat;
      int unsigned hold;
      int          holds_seen;
      mode       = 0;
      left       = 0;
      beat       = 0;
      hold       = 0;
      holds_seen = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         beat++;
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold       = HOLD_CYCLES;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         if (hold != 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (beat % 5) != 0;
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("periodic_tick_compare_scheduler: mismatch");
      $finish;
   end

   initial begin : stimulus
      plan_row_type          plan [$];
      plan_row_type          row;
      logic [TICK_W-1:0]     step;
      logic [TICK_W-1:0]     now;
      logic [CSR_DATA_W-1:0] wdata;
      logic                  action;
      int unsigned           pick;
      int unsigned           span;
      int unsigned           burst;
      int unsigned           gap;
      bit                    steady;

      reset         <= 1'b1;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_PERIOD;
      csr_wdata     <= '0;
      req_valid     <= 1'b0;
      req_action    <= ACTION_RESTART;
      req_now_ticks <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      ms_model     = '0;
      target_model = {44'd0, PERIOD_RESET};
      period_model = PERIOD_RESET;
      slack_model  = SLACK_RESET;
      @(posedge clock);

      plan.push_back(typed_row(ACTION_COMPARE, 64'd0, 32'd1, 64'd12000));
      plan.push_back(word_row(ACTION_COMPARE, 64'd11990));
      // lands inside the slack window
      plan.push_back(word_row(ACTION_COMPARE, 64'd23990));
      // counter exactly on the new target
      plan.push_back(word_row(ACTION_COMPARE, 64'd35990));
      plan.push_back(word_row(ACTION_COMPARE, '1));
      plan.push_back(typed_row(ACTION_RESTART, '1, 32'd0, 64'd6000));
      // distance of exactly minus half the counter range
      plan.push_back(word_row(ACTION_COMPARE, 64'h8000_0000_0000_2EE0));
      plan.push_back(typed_row(ACTION_RESTART, 64'd0, 32'd0, 64'd6000));
      plan.push_back(word_row(ACTION_COMPARE, 64'h7FFF_FFFF_FFFF_FFFF));
      // zero period behaves as one tick
      plan.push_back(csr_row(CSR_PERIOD, 20'd0));
      plan.push_back(csr_row(CSR_SLACK, 20'd0));
      plan.push_back(typed_row(ACTION_RESTART, 64'h5555_AAAA_5555_AAAA, 32'd0, 64'd1));
      plan.push_back(word_row(ACTION_COMPARE, 64'd1));
      plan.push_back(word_row(ACTION_COMPARE, 64'h8000_0000_0000_0002));
      // slack write with bits above its width
      plan.push_back(csr_row(CSR_PERIOD, 20'hFFFFF));
      plan.push_back(csr_row(CSR_SLACK, 20'hFFFFF));
      plan.push_back(typed_row(ACTION_RESTART, 64'd0, 32'd0, 64'hFFFFF));
      plan.push_back(word_row(ACTION_COMPARE, 64'h1FFF9A));
      plan.push_back(word_row(ACTION_COMPARE, 64'h0123_4567_89AB_CDEF));
      plan.push_back(csr_row(CSR_PERIOD, 20'd1000));
      plan.push_back(csr_row(CSR_SLACK, 20'd100));
      plan.push_back(word_row(ACTION_RESTART, 64'hAAAA_5555_AAAA_5555));
      plan.push_back(word_row(ACTION_COMPARE, 64'd0));
      plan.push_back(word_row(ACTION_COMPARE, 64'd5_000_000));
      plan.push_back(word_row(ACTION_COMPARE, 64'd5_000_950));

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            req_valid <= 1'b0;
            settle();
            write_csr(row.idx, row.data);
         end else begin
            send_word(row.action, row.now, row.typed, row.want);
         end
      end
      req_valid <= 1'b0;
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case ($urandom_range(0, 7))
            0: wdata = '0;
            1: wdata = 20'd1;
            2: wdata = '1;
            3: wdata = 20'd1000;
            4: wdata = 20'd1000000;
            default: wdata = CSR_DATA_W'($urandom_range(1000, 1000000));
         endcase
         write_csr(CSR_PERIOD, wdata);
         case ($urandom_range(0, 5))
            0: wdata = '0;
            1: wdata = 20'h0FFFF;
            2: wdata = 20'hFFFFF;
            3: wdata = 20'($urandom);
            default: wdata = CSR_DATA_W'($urandom_range(0, 200));
         endcase
         write_csr(CSR_SLACK, wdata);

         steady = ($urandom_range(0, 3) == 0);
         burst  = $urandom_range(1, 16);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // long receiver stall while words keep coming
            if (ph == 2 && n == 10) holds_asked++;
            step   = (period_model == '0) ? 64'd1 : {44'd0, period_model};
            span   = step[31:0];
            action = ACTION_COMPARE;
            pick   = $urandom_range(0, 99);
            if (pick < 4) begin
               action = ACTION_RESTART;
               now    = {$urandom, $urandom};
            end else if (pick < 60) begin
               // match handled shortly after the armed target
               now = target_model + TICK_W'($urandom_range(0, 200));
            end else if (pick < 80) begin
               // around the edge of the slack window
               now = target_model + step - {48'd0, slack_model} - 64'd40
                     + TICK_W'($urandom_range(0, slack_model + 80));
            end else if (pick < 92) begin
               // several periods missed
               now = target_model + step * TICK_W'($urandom_range(1, 40))
                     + TICK_W'($urandom_range(0, span - 1));
            end else if (pick < 96) begin
               now = target_model - TICK_W'($urandom_range(0, 1000));
            end else begin
               now = {$urandom, $urandom};
            end
            send_word(action, now, 1'b0, '0);
            if (!steady) begin
               if (burst <= 1) begin
                  gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                    : $urandom_range(1, 8);
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
                  burst = $urandom_range(1, 16);
               end else begin
                  burst--;
               end
            end
         end
         req_valid <= 1'b0;
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_ticks.size() == 0)
         $display("periodic_tick_compare_scheduler: match");
      else
         $display("periodic_tick_compare_scheduler: mismatch");
      $finish;
   end

endmodule
